// ----- sv/bitmap_page_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Checked only while out of reset.
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, constants and helpers shared by the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_W            = 12;
  localparam int WORD_W            = 32;
  localparam int WORD_LSB          = 5;
  localparam int MAX_PAGES_DEF     = 4096;
  localparam int INITIAL_PAGES_DEF = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_MARK  = 1'b1
  } op_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic clr;       // zero one bitmap word at the sweep pointer
    logic load;      // capture the request
    logic scan_rd;   // read the next word of the search
    logic take_hit;  // latch the page found by the search
    logic grow;      // take the page at the count, bump the count
    logic rmw_rd;    // read the word of the target page
    logic rmw_wr;    // set the target bit, report success
    logic fail;      // report failure
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic clr_last;
    logic mark_ok;
    logic scan_done;
    logic pending;
    logic hit;
    logic can_grow;
  } ctrl_status_t;

  // Index of the lowest set bit of a word; zero when none is set.
  function automatic logic [WORD_LSB-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_LSB-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_LSB'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page allocator over a used-page bitmap. A request is taken when
// start is high and busy is low; its single result appears on page_o/ok_o for
// exactly one cycle with done_o high, and is never held back. After reset the
// block sweeps the bitmap memory to zero, one 32-bit word per cycle, and stays
// busy until done. A mark request reads the word of its page and writes it back
// with the bit set; a page out of range fails without touching the memory. An
// allocate request scans the bitmap memory one word per cycle from the search
// floor word up to the page count; when no free page lies below the count, it
// takes the page at the count and grows the count, or fails when the count is
// not below MaxPages. The single read port of the bitmap memory limits the scan
// to one word at a time. The search floor is written through the cfg channel,
// which is always ready.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int MaxPages     = bpa_pkg::MAX_PAGES_DEF,
  parameter int InitialPages = bpa_pkg::INITIAL_PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  page_index_i,
  output logic                        done_o,
  output logic [bpa_pkg::PAGE_W-1:0]  page_o,
  output logic                        ok_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpa_pkg::PAGE_W-1:0]  cfg_data_i
);
  import bpa_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  op_e          op;

  assign op          = op_e'(operation_i);
  assign cfg_ready_o = 1'b1;

  bpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (op),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  bpa_datapath #(
    .MaxPages     (MaxPages),
    .InitialPages (InitialPages)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .page_index_i (page_index_i),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .page_o       (page_o),
    .ok_o         (ok_o)
  );

endmodule

// ----- sv/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: bitmap clear sweep, word scan, read-modify-write of one word.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  bpa_pkg::op_e            op_i,
  input  bpa_pkg::ctrl_status_t   status_i,
  output bpa_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy_o
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_WR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (op_i == OP_MARK) begin
            if (status_i.mark_ok) begin
              state_d = ST_RD;
            end else begin
              cmd_o.fail = 1'b1;
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = ST_WR;
        end else if (status_i.scan_done && !status_i.pending) begin
          // nothing free below the count: grow or give up
          if (status_i.can_grow) begin
            cmd_o.grow = 1'b1;
            state_d    = ST_RD;
          end else begin
            cmd_o.fail = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (!status_i.scan_done) begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      ST_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = ST_WR;
      end
      ST_WR: begin
        cmd_o.rmw_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- sv/bpa_datapath.sv -----
// ----------------------------------------------------------------------------
// bpa_datapath
// Used-page bitmap memory, search window, page count, result registers.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int MaxPages     = bpa_pkg::MAX_PAGES_DEF,
  parameter int InitialPages = bpa_pkg::INITIAL_PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpa_pkg::ctrl_cmd_t          cmd_i,
  output bpa_pkg::ctrl_status_t       status_o,
  input  logic [bpa_pkg::PAGE_W-1:0]  page_index_i,
  input  logic                        cfg_we_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  cfg_data_i,
  output logic                        done_o,
  output logic [bpa_pkg::PAGE_W-1:0]  page_o,
  output logic                        ok_o
);
  import bpa_pkg::*;

  localparam int WordCount = (MaxPages + WORD_W - 1) / WORD_W;
  localparam int AW        = $clog2(WordCount);
  localparam int TW        = $clog2(MaxPages);
  localparam int CntMax    = (MaxPages > InitialPages) ? MaxPages : InitialPages;
  localparam int CntW      = $clog2(CntMax + 1);
  localparam int PtrW      = (AW + 1 > PAGE_W - WORD_LSB) ? AW + 1 : PAGE_W - WORD_LSB;
  localparam int CmpW      = (PtrW + WORD_LSB > CntW) ? PtrW + WORD_LSB : CntW;

  logic [WORD_W-1:0] mem [WordCount];
  logic [WORD_W-1:0] rdata_q;
  logic [AW-1:0]     ew_q;
  logic              ev_q;
  logic [PtrW-1:0]   ptr_q;
  logic [TW-1:0]     target_q;
  logic [CntW-1:0]   cnt_q;
  logic [PAGE_W-1:0] start_q;
  logic              done_q;
  logic [PAGE_W-1:0] page_q;
  logic              ok_q;

  logic [CntW-1:0]     max_cnt;
  logic [CntW-1:0]     limit;
  logic                scan_done;
  logic [WORD_W-1:0]   lo_mask;
  logic [WORD_W-1:0]   hi_mask;
  logic [WORD_W-1:0]   cand;
  logic                hit;
  logic [WORD_LSB-1:0] hit_bit;
  logic [AW-1:0]       tgt_word;
  logic [AW-1:0]       raddr;
  logic                rd_en;

  assign max_cnt = CntW'(MaxPages);
  assign limit   = (cnt_q < max_cnt) ? cnt_q : max_cnt;

  // search has run past the last page below the limit
  assign scan_done = (CmpW'({ptr_q, {WORD_LSB{1'b0}}}) >= CmpW'(limit));

  // window of the word under evaluation: at or above the search floor, below the limit
  assign lo_mask = (CmpW'(ew_q) == CmpW'(start_q[PAGE_W-1:WORD_LSB]))
                 ? ~((WORD_W'(1) << start_q[WORD_LSB-1:0]) - WORD_W'(1)) : '1;
  assign hi_mask = (CmpW'(ew_q) == CmpW'(limit >> WORD_LSB))
                 ? ((WORD_W'(1) << limit[WORD_LSB-1:0]) - WORD_W'(1)) : '1;
  assign cand    = ~rdata_q & lo_mask & hi_mask;
  assign hit     = ev_q & (|cand);
  assign hit_bit = lowest_set(cand);

  assign tgt_word = AW'(target_q >> WORD_LSB);
  assign raddr    = cmd_i.rmw_rd ? tgt_word : AW'(ptr_q);
  assign rd_en    = cmd_i.rmw_rd | cmd_i.scan_rd;

  assign status_o.clr_last  = (ptr_q == PtrW'(WordCount - 1));
  assign status_o.mark_ok   = (32'(page_index_i) < 32'(MaxPages));
  assign status_o.scan_done = scan_done;
  assign status_o.pending   = ev_q;
  assign status_o.hit       = hit;
  assign status_o.can_grow  = (cnt_q < max_cnt);

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[AW'(ptr_q)] <= '0;
    end else if (cmd_i.rmw_wr) begin
      mem[tgt_word] <= rdata_q | (WORD_W'(1) << target_q[WORD_LSB-1:0]);
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      ev_q    <= 1'b0;
      cnt_q   <= CntW'(InitialPages);
      start_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.clr || cmd_i.scan_rd) begin
        ptr_q <= ptr_q + PtrW'(1);
      end else if (cmd_i.load) begin
        ptr_q <= PtrW'(start_q[PAGE_W-1:WORD_LSB]);
      end
      ev_q <= cmd_i.scan_rd;
      if (cmd_i.grow) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
      done_q <= cmd_i.rmw_wr | cmd_i.fail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      ew_q <= AW'(ptr_q);
    end
    if (cmd_i.load) begin
      target_q <= TW'(page_index_i);
    end else if (cmd_i.take_hit) begin
      target_q <= TW'({ew_q, hit_bit});
    end else if (cmd_i.grow) begin
      target_q <= TW'(cnt_q);
    end
    if (cmd_i.rmw_wr || cmd_i.fail) begin
      page_q <= cmd_i.rmw_wr ? PAGE_W'(target_q) : '0;
      ok_q   <= cmd_i.rmw_wr;
    end
  end

  assign done_o = done_q;
  assign page_o = page_q;
  assign ok_o   = ok_q;

endmodule

// ----- sv/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_core_macros.svh"

module bpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [bpa_pkg::PAGE_W-1:0]  page_o,
  input logic                        ok_o
);

  // a failed request reports page zero
  `BPA_ASSERT(a_fail_page_zero, done_o && !ok_o |-> page_o == '0, "failure with nonzero page")

  // a result only follows a request in flight or one taken on that edge
  `BPA_ASSERT(a_done_after_work, done_o |-> $past(busy || start), "result without request")

  // the clear sweep holds the block busy coming out of reset
  `BPA_ASSERT_ALWAYS(a_busy_after_reset, !rst_ni |=> busy, "idle during reset sweep")

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .page_o (page_o),
  .ok_o   (ok_o)
);
